### rtl/longest_uniform_run_tracker_assert.svh
// Assertion macros used by the run tracker top level.
`ifndef LONGEST_UNIFORM_RUN_TRACKER_ASSERT_SVH
`define LONGEST_UNIFORM_RUN_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define LURT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define LURT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lurt_pkg.sv
// Shared types and constants of the longest uniform run tracker.
`timescale 1ns / 1ps
package lurt_pkg;

    localparam int LEAVES_DEFAULT = 1024;
    localparam int POS_MAX_W      = 16;   // leaf index bits for the largest tree
    localparam int SYM_W          = 8;
    localparam int OUT_W          = 11;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 report;
        logic [POS_MAX_W-1:0] pos;
        logic [SYM_W-1:0]     sym;
    } op_t;

    typedef struct packed {
        logic busy;
        logic clearing;
    } back_status_t;

endpackage

### rtl/longest_uniform_run_tracker.sv
// Top level of the longest uniform run tracker.
`timescale 1ns / 1ps
`include "longest_uniform_run_tracker_assert.svh"
// Tracks a string of LEAVES byte symbols in a segment tree held in one RAM of
// 2*P node words (P = LEAVES rounded up to a power of two, heap order, root
// at address 1). Each request carries a command: clear empties every position,
// load writes a symbol silently, update writes a symbol and returns the
// longest run of one repeated symbol over the whole string. Positions at or
// beyond LEAVES are not written; an update there still reports the current
// longest run. Command code 3 is dropped. A front end classifies requests
// into a two-entry queue; the back end works on one operation at a time. The
// sibling reads for all tree levels are issued one per cycle through the RAM
// read port while each merge follows in the cycle after its read, writing one
// parent per cycle, so a walk climbs every tree level from leaf to root. An
// update then waits, if need be, until the previous result leaves the output
// register. A clear, and the pass that follows reset, sweeps all 2*P RAM words
// one per cycle while no operation starts; requests still queue until the
// queue fills.
module longest_uniform_run_tracker #(
    parameter int LEAVES = lurt_pkg::LEAVES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command[1:0], position[11:2], symbol[19:12], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // longest_run[10:0], zeros
);
    lurt_pkg::op_t          op;
    logic                   op_vld, op_rdy;
    lurt_pkg::back_status_t st;
    logic [lurt_pkg::OUT_W-1:0] longest_run;

    // Classify and queue each request.
    lurt_front #(.LEAVES(LEAVES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .command  (s_axis_tdata[1:0]),
        .position (s_axis_tdata[11:2]),
        .symbol   (s_axis_tdata[19:12]),
        .op_valid (op_vld),
        .op_ready (op_rdy),
        .op       (op)
    );

    // Run the clear sweep or the merge walk, then hold the result.
    lurt_back #(.LEAVES(LEAVES)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op_valid    (op_vld),
        .op_ready    (op_rdy),
        .op          (op),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .longest_run (longest_run),
        .status      (st)
    );

    assign m_axis_tdata = {5'b0, longest_run};

    // Queue head holds while the back end is not ready.
    `LURT_ASSERT_NXT(a_queue_hold, op_vld && !op_rdy, op_vld && $stable(op), "queue head lost")
    // A result appears only at the end of a running operation.
    `LURT_ASSERT_IMP(a_result_src, $rose(m_axis_tvalid), $past(st.busy), "stray result")
    // No operation starts during the clear sweep.
    `LURT_ASSERT_IMP(a_clr_block, st.clearing, !op_rdy, "operation taken while clearing")
endmodule

### rtl/lurt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lurt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/lurt_front.sv
// Front end: accept requests, classify them, and queue operations.
`timescale 1ns / 1ps
module lurt_front #(
    parameter int LEAVES = lurt_pkg::LEAVES_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      command,
    input  logic [9:0]      position,
    input  logic [7:0]      symbol,
    output logic            op_valid,
    input  logic            op_ready,
    output lurt_pkg::op_t   op
);
    lurt_pkg::op_t q0_reg, q0_next, q1_reg, q1_next, cls;
    logic [1:0]    cnt_reg, cnt_next;
    logic          in_range, keep, push, pop;
    logic [lurt_pkg::POS_MAX_W+9:0] pos_ext;

    assign in_range = 32'(position) < LEAVES;
    assign pos_ext  = {{lurt_pkg::POS_MAX_W{1'b0}}, position};

    // Drop unused codes and out-of-range loads; out-of-range updates become report-only.
    always_comb begin
        cls.pos    = pos_ext[lurt_pkg::POS_MAX_W-1:0];
        cls.sym    = symbol;
        cls.report = 1'b0;
        cls.kind   = lurt_pkg::OP_WRITE;
        keep       = 1'b0;
        unique case (command)
            lurt_pkg::CMD_CLEAR: begin
                cls.kind = lurt_pkg::OP_CLEAR;
                keep     = 1'b1;
            end
            lurt_pkg::CMD_LOAD: begin
                keep = in_range;
            end
            lurt_pkg::CMD_UPDATE: begin
                cls.report = 1'b1;
                cls.kind   = in_range ? lurt_pkg::OP_WRITE : lurt_pkg::OP_REPORT;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q0_reg;
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = op_valid && op_ready;

    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            q0_next = q1_reg;
        end
        if (push) begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)) begin
                q0_next = cls;
            end else begin
                q1_next = cls;
            end
        end
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end
endmodule

### rtl/lurt_back.sv
// Back end: clear sweep, leaf-to-root merge walk, and result register.
`timescale 1ns / 1ps
module lurt_back #(
    parameter int LEAVES = lurt_pkg::LEAVES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       op_valid,
    output logic                       op_ready,
    input  lurt_pkg::op_t              op,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lurt_pkg::OUT_W-1:0] longest_run,
    output lurt_pkg::back_status_t     status
);
    localparam int D  = $clog2(LEAVES);       // tree height
    localparam int AW = D + 1;                // node address bits
    localparam int RW = $clog2(LEAVES + 1);   // run length bits
    localparam int NW = 3 * RW + 18;          // node word
    localparam int HW = $clog2(D + 1);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // node word: {longest, prefix, suffix, left sym, right sym}, bit 8 of a sym = empty
    localparam logic [NW-1:0] EMPTY_NODE = {{(3*RW){1'b0}}, 9'h100, 9'h100};

    function automatic logic [NW-1:0] merge(input logic [NW-1:0] a,
                                            input logic [NW-1:0] b,
                                            input logic [RW-1:0] len);
        logic [RW-1:0] al, ap, as_, bl, bp, bs, best, pre, suf, j;
        logic [8:0]    ars, bls;
        al  = a[NW-1 -: RW];  ap = a[NW-1-RW -: RW];  as_ = a[NW-1-2*RW -: RW];
        bl  = b[NW-1 -: RW];  bp = b[NW-1-RW -: RW];  bs  = b[NW-1-2*RW -: RW];
        ars = a[8:0];
        bls = b[17:9];
        best = (al > bl) ? al : bl;
        pre  = ap;
        suf  = bs;
        j    = as_ + bp;
        if (!ars[8] && ars == bls) begin
            if (j > best) begin
                best = j;
            end
            if (ap == len) begin
                pre = len + bp;
            end
            if (bs == len) begin
                suf = len + as_;
            end
        end
        return {best, pre, suf, a[17:9], b[8:0]};
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next, leaf_reg, leaf_next;
    logic [HW-1:0] rd_h_reg, rd_h_next, mg_h_reg;
    logic          rd_act_reg, rd_act_next, mg_act_reg, rep_reg, rep_next;
    logic [NW-1:0] cur_reg, cur_next, sib, parent, leaf_word;
    logic [RW-1:0] root_reg, root_next, span;
    logic          m_tvalid_reg, m_tvalid_next, out_free;
    logic [RW-1:0] out_reg, out_next;
    logic [AW-1:0] node_idx, rd_addr, wr_addr;
    logic          wr_en;
    logic [NW-1:0] wr_data;
    logic [RW+lurt_pkg::OUT_W-1:0] out_ext;
    logic [lurt_pkg::POS_MAX_W+AW-1:0] pos_ext;

    assign pos_ext   = {{AW{1'b0}}, op.pos};
    assign leaf_word = {RW'(1), RW'(1), RW'(1), 1'b0, op.sym, 1'b0, op.sym};
    assign node_idx  = leaf_reg >> mg_h_reg;
    assign span      = RW'(1) << mg_h_reg;
    assign parent    = node_idx[0] ? merge(sib, cur_reg, span) : merge(cur_reg, sib, span);
    assign rd_addr   = (leaf_reg >> rd_h_reg) ^ AW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign op_ready  = (state_reg == ST_IDLE);

    lurt_ram #(.WIDTH(NW), .DEPTH(2 ** AW)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_act_reg),
        .rd_addr (rd_addr),
        .rd_data (sib)
    );

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        leaf_next     = leaf_reg;
        rd_h_next     = rd_h_reg;
        rd_act_next   = rd_act_reg;
        rep_next      = rep_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wr_en         = 1'b0;
        wr_addr       = clr_reg;
        wr_data       = EMPTY_NODE;
        unique case (state_reg)
            ST_CLR: begin
                wr_en     = 1'b1;
                root_next = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (op_valid) begin
                    rep_next = op.report;
                    unique case (op.kind)
                        lurt_pkg::OP_CLEAR: begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        lurt_pkg::OP_WRITE: begin
                            leaf_next   = {1'b1, pos_ext[D-1:0]};
                            wr_en       = 1'b1;
                            wr_addr     = {1'b1, pos_ext[D-1:0]};
                            wr_data     = leaf_word;
                            cur_next    = leaf_word;
                            rd_h_next   = '0;
                            rd_act_next = 1'b1;
                            state_next  = ST_WALK;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (rd_act_reg) begin
                    rd_h_next = rd_h_reg + HW'(1);
                    if (rd_h_reg == HW'(D - 1)) begin
                        rd_act_next = 1'b0;
                    end
                end
                if (mg_act_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = node_idx >> 1;
                    wr_data  = parent;
                    cur_next = parent;
                    if (mg_h_reg == HW'(D - 1)) begin
                        root_next  = parent[NW-1 -: RW];
                        state_next = rep_reg ? ST_DONE : ST_IDLE;
                    end
                end
            end
            default: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_next      = root_reg;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            rd_act_reg   <= 1'b0;
            mg_act_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            root_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            rd_act_reg   <= rd_act_next;
            mg_act_reg   <= rd_act_reg;
            m_tvalid_reg <= m_tvalid_next;
            root_reg     <= root_next;
        end
        leaf_reg <= leaf_next;
        rd_h_reg <= rd_h_next;
        mg_h_reg <= rd_h_reg;
        rep_reg  <= rep_next;
        cur_reg  <= cur_next;
        out_reg  <= out_next;
    end

    assign out_ext         = {{lurt_pkg::OUT_W{1'b0}}, out_reg};
    assign longest_run     = out_ext[lurt_pkg::OUT_W-1:0];
    assign m_tvalid        = m_tvalid_reg;
    assign status.busy     = (state_reg == ST_WALK) || (state_reg == ST_DONE);
    assign status.clearing = (state_reg == ST_CLR);
endmodule
